>>> hw/rtl/tbdr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tbdr_pkg;

    localparam int unsigned STEP_W      = 8;
    localparam int unsigned BUTTONS_W   = 2;
    localparam int unsigned CODE_W      = 3;
    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned IN_TDATA_W  = 8;
    localparam int unsigned OUT_TDATA_W = 8;
    localparam int unsigned RESULT_W    = 2 * CODE_W;

    localparam logic [STEP_W-1:0] DEBOUNCE_RESET = STEP_W'(5);
    localparam logic [STEP_W-1:0] HOLD_RESET     = STEP_W'(50);
    localparam logic [STEP_W-1:0] REPEAT_RESET   = STEP_W'(10);

    typedef enum logic [CODE_W-1:0] {
        KEY_NONE    = 3'd0,
        KEY_RED     = 3'd1,
        KEY_GREEN   = 3'd2,
        KEY_BOTH    = 3'd3,
        KEY_INVALID = 3'd4
    } key_state_t;

    typedef enum logic [CODE_W-1:0] {
        EV_NONE  = 3'd0,
        EV_RED   = 3'd1,
        EV_GREEN = 3'd2,
        EV_LONG  = 3'd3,
        EV_SHORT = 3'd4
    } event_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_DEBOUNCE = 2'd0,
        REG_HOLD     = 2'd1,
        REG_REPEAT   = 2'd2
    } reg_index_t;

    typedef struct packed {
        logic [STEP_W-1:0] debounce_steps;
        logic [STEP_W-1:0] hold_steps;
        logic [STEP_W-1:0] repeat_steps;
    } cfg_t;

    typedef struct packed {
        key_state_t           key_state;
        logic [BUTTONS_W-1:0] prev_sample;
        logic                 prev_valid;
        logic [STEP_W-1:0]    steps_left;
    } track_t;

endpackage

`default_nettype wire

>>> hw/rtl/tbdr_step.sv
`timescale 1ns / 1ps
`default_nettype none

module tbdr_step
(
    input  wire tbdr_pkg::track_t                   cur_track,
    input  wire tbdr_pkg::cfg_t                     cfg,
    input  wire logic [tbdr_pkg::BUTTONS_W-1:0]     sample,
    output tbdr_pkg::track_t                        next_track,
    output tbdr_pkg::event_t                        ev
);
    import tbdr_pkg::*;

    logic              same;
    logic [STEP_W-1:0] counted;

    always_comb
    begin
        same    = cur_track.prev_valid && (sample == cur_track.prev_sample);
        counted = same ? cur_track.steps_left - STEP_W'(1) : cur_track.steps_left;

        next_track             = cur_track;
        next_track.steps_left  = counted;
        next_track.prev_sample = sample;
        next_track.prev_valid  = 1'b1;
        ev                     = EV_NONE;

        if (counted == '0)
        begin
            // Counter expired: the planned transition of the qualified state.
            unique case (cur_track.key_state)
                KEY_NONE:
                begin
                    next_track.key_state = key_state_t'({1'b0, sample});
                    if (sample == '0)
                    begin
                        next_track.steps_left = cfg.debounce_steps;
                    end
                    else
                    begin
                        next_track.steps_left = cfg.hold_steps;
                        if (sample == BUTTONS_W'(KEY_RED))
                        begin
                            ev = EV_RED;
                        end
                        else if (sample == BUTTONS_W'(KEY_GREEN))
                        begin
                            ev = EV_GREEN;
                        end
                    end
                end
                KEY_RED:
                begin
                    next_track.steps_left = cfg.repeat_steps;
                    ev = EV_RED;
                end
                KEY_GREEN:
                begin
                    next_track.steps_left = cfg.repeat_steps;
                    ev = EV_GREEN;
                end
                KEY_BOTH:
                begin
                    ev = EV_LONG;
                    next_track.key_state  = KEY_INVALID;
                    next_track.steps_left = cfg.debounce_steps;
                end
                default:
                begin
                    if (sample == '0)
                    begin
                        next_track.key_state = KEY_NONE;
                    end
                    next_track.steps_left = cfg.debounce_steps;
                end
            endcase
        end
        else if (!same)
        begin
            // A change before expiry restarts debouncing or spoils the press.
            if (cur_track.key_state == KEY_NONE)
            begin
                next_track.steps_left = cfg.debounce_steps;
            end
            else
            begin
                if (cur_track.key_state == KEY_BOTH)
                begin
                    ev = EV_SHORT;
                end
                next_track.key_state  = KEY_INVALID;
                next_track.steps_left = cfg.debounce_steps;
            end
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/tbdr_out_buf.sv
`timescale 1ns / 1ps
`default_nettype none

module tbdr_out_buf
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire logic [tbdr_pkg::RESULT_W-1:0]    in_data,
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output logic [tbdr_pkg::RESULT_W-1:0]         out_data
);
    import tbdr_pkg::*;

    logic                main_valid_reg, main_valid_next;
    logic                skid_valid_reg, skid_valid_next;
    logic [RESULT_W-1:0] main_data_reg, main_data_next;
    logic [RESULT_W-1:0] skid_data_reg, skid_data_next;
    logic                in_acc;

    assign in_ready  = !skid_valid_reg;
    assign in_acc    = in_valid && !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_data_reg;

    always_comb
    begin
        main_valid_next = main_valid_reg;
        main_data_next  = main_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (out_ready || !main_valid_reg)
        begin
            // The skid entry is older than anything arriving now.
            main_valid_next = skid_valid_reg || in_acc;
            main_data_next  = skid_valid_reg ? skid_data_reg : in_data;
            skid_valid_next = 1'b0;
        end
        else if (in_acc)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = in_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_data_reg <= main_data_next;
        skid_data_reg <= skid_data_next;
    end

endmodule

`default_nettype wire

>>> hw/rtl/two_button_debounce_repeat_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Two-button debounce with auto-repeat and long/short two-button press.
// Input stream: one request per sample tick, s_tdata[1:0] holds the buttons
// (bit 0 red, bit 1 green, active high). Output stream: one request per input,
// m_tdata[2:0] is the event code (none, red, green, both long, both short) and
// m_tdata[5:3] the qualified state after the sample (none, red, green, both,
// invalid).
// A sample is taken on the cycle it is accepted; its result is registered in
// the output buffer. One sample can be accepted every cycle, limited only
// by the two-entry output buffer: when the receiver stalls, one more result
// is held in the skid entry and s_tready drops until the receiver drains it.
// The three step registers (debounce, hold, repeat) are written through the
// cfg port and take effect the next time the step counter is reloaded.
// Reset returns the registers to 5, 50 and 10, the qualified state to none,
// the counter to 5, empties the output buffer and makes the first sample
// after reset count as a change.
module two_button_debounce_repeat_core
#(
    parameter logic [tbdr_pkg::STEP_W-1:0] DEBOUNCE_INIT = tbdr_pkg::DEBOUNCE_RESET,
    parameter logic [tbdr_pkg::STEP_W-1:0] HOLD_INIT     = tbdr_pkg::HOLD_RESET,
    parameter logic [tbdr_pkg::STEP_W-1:0] REPEAT_INIT   = tbdr_pkg::REPEAT_RESET
)
(
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    input  wire logic [tbdr_pkg::IN_TDATA_W-1:0]      s_tdata,  // [1:0] buttons
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    output logic [tbdr_pkg::OUT_TDATA_W-1:0]          m_tdata,  // [2:0] event_code,
                                                                // [5:3] qualified_state
    input  wire logic                                 cfg_we,
    input  wire logic [tbdr_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  wire logic [tbdr_pkg::STEP_W-1:0]          cfg_data
);
    import tbdr_pkg::*;

    cfg_t                cfg_reg;
    track_t              track_reg;
    track_t              track_next;
    event_t              ev;
    logic                in_acc;
    logic [RESULT_W-1:0] result;
    logic [RESULT_W-1:0] out_result;

    assign in_acc = s_tvalid && s_tready;

    tbdr_step u_step
    (
        .cur_track  (track_reg),
        .cfg        (cfg_reg),
        .sample     (s_tdata[BUTTONS_W-1:0]),
        .next_track (track_next),
        .ev         (ev)
    );

    assign result = {track_next.key_state, ev};

    tbdr_out_buf u_out_buf
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (result),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_result)
    );

    assign m_tdata = {(OUT_TDATA_W - RESULT_W)'(0), out_result};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_steps <= DEBOUNCE_INIT;
            cfg_reg.hold_steps     <= HOLD_INIT;
            cfg_reg.repeat_steps   <= REPEAT_INIT;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_DEBOUNCE: cfg_reg.debounce_steps <= cfg_data;
                REG_HOLD:     cfg_reg.hold_steps     <= cfg_data;
                REG_REPEAT:   cfg_reg.repeat_steps   <= cfg_data;
                default:      ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            track_reg.key_state   <= KEY_NONE;
            track_reg.prev_sample <= '0;
            track_reg.prev_valid  <= 1'b0;
            track_reg.steps_left  <= DEBOUNCE_INIT;
        end
        else if (in_acc)
        begin
            track_reg <= track_next;
        end
    end

endmodule

`default_nettype wire
